FILE: rtl/bhpc_pkg.sv
// Shared types and constants for the hull point classifier.
// Item structs, operation and register codes, distance status struct.
// No dependencies.
`timescale 1ns / 1ps

package bhpc_pkg;

   localparam int IDX_W   = 12;
   localparam int CHILD_W = 16;
   localparam int KIND_W  = 3;
   localparam int WORD_W  = 32;
   localparam int CSR_W   = 12;

   // operation codes of an input item
   localparam logic [1:0] OP_WRITE_NODE  = 2'd0;
   localparam logic [1:0] OP_WRITE_PLANE = 2'd1;
   localparam logic [1:0] OP_CLASSIFY    = 2'd2;

   // configuration register indexes
   localparam logic CSR_FIRST_NODE = 1'b0;
   localparam logic CSR_LAST_NODE  = 1'b1;

   localparam logic [CSR_W-1:0] FIRST_NODE_RESET = 12'd0;
   localparam logic [CSR_W-1:0] LAST_NODE_RESET  = 12'hFFF;

   // plane kinds: below AXIAL_KINDS the plane is axis aligned
   localparam logic [KIND_W-1:0] KIND_X      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_Y      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_Z      = 3'd2;
   localparam logic [KIND_W-1:0] AXIAL_KINDS = 3'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic [IDX_W-1:0]         index;
      logic [IDX_W-1:0]         plane_ref;
      logic signed [CHILD_W-1:0] child_front;
      logic signed [CHILD_W-1:0] child_back;
      logic [KIND_W-1:0]        plane_kind;
      logic signed [WORD_W-1:0] vec_x;
      logic signed [WORD_W-1:0] vec_y;
      logic signed [WORD_W-1:0] vec_z;
      logic signed [WORD_W-1:0] plane_dist;
   } req_type;

   typedef struct packed {
      logic signed [CHILD_W-1:0] contents;
      logic                      bad_node;
   } rsp_type;

   // status of the signed distance unit
   typedef struct packed {
      logic done;
      logic neg;
   } dist_rsp_type;

endpackage

FILE: rtl/bhpc_rem_const.sv
// Remainder of a 12-bit index by a constant divisor.
// Reciprocal multiply, registered, then one multiply, subtract and correction.
// Depends on bhpc_pkg.
`timescale 1ns / 1ps

module bhpc_rem_const
   import bhpc_pkg::*;
#(
   parameter int DIV = 4096
) (
   input  logic                     clock,
   input  logic [IDX_W-1:0]         value,
   output logic [$clog2(DIV)-1:0]   rem
);

   localparam int RW = $clog2(DIV);
   localparam int SH = 2 * IDX_W;
   localparam int PW = IDX_W + SH;
   localparam int MW = IDX_W + RW + 1;
   localparam logic [SH-1:0] RECIP = SH'((1 << SH) / DIV);
   localparam logic [MW-1:0] DIV_V = MW'(DIV);

   logic [PW-1:0]    recip_prod;
   logic [IDX_W-1:0] quot_ff;
   logic [IDX_W-1:0] value_ff;
   logic [MW-1:0]    back_prod;
   logic [MW-1:0]    diff;
   logic [MW-1:0]    rem_raw;
   logic [MW-1:0]    rem_fix;

   // estimate the quotient, low by at most one
   assign recip_prod = PW'(value) * PW'(RECIP);

   always_ff @(posedge clock) begin
      quot_ff  <= recip_prod[PW-1:SH];
      value_ff <= value;
   end

   // subtract back and correct once
   assign back_prod = MW'(quot_ff) * DIV_V;
   assign diff      = MW'(value_ff) - back_prod;
   assign rem_raw   = MW'(diff[IDX_W-1:0]);
   assign rem_fix   = (rem_raw >= DIV_V) ? (rem_raw - DIV_V) : rem_raw;
   assign rem       = RW'(rem_fix);

endmodule

FILE: rtl/bhpc_dist_unit.sv
// Signed point-to-plane distance test for one node.
// Axial planes finish straight from idle; general planes run three products
// through one shared multiplier, then accumulate, floor-shift and subtract.
// Depends on bhpc_pkg.
`timescale 1ns / 1ps

module bhpc_dist_unit
   import bhpc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [KIND_W-1:0]           kind,
   input  logic signed [FRAC_BITS+1:0] norm_x,
   input  logic signed [FRAC_BITS+1:0] norm_y,
   input  logic signed [FRAC_BITS+1:0] norm_z,
   input  logic signed [WORD_W-1:0]    plane_offset,
   input  logic signed [WORD_W-1:0]    pt_x,
   input  logic signed [WORD_W-1:0]    pt_y,
   input  logic signed [WORD_W-1:0]    pt_z,
   output dist_rsp_type                status
);

   localparam int NB  = FRAC_BITS + 2;
   localparam int PRW = WORD_W + NB;
   localparam int ACW = PRW + 2;
   localparam int DW  = ACW - FRAC_BITS + 1;
   localparam int AXW = WORD_W + 1;

   typedef enum logic [1:0] {
      D_IDLE,
      D_MUL,
      D_FINAL
   } dstate_type;

   dstate_type             state_ff;
   logic [1:0]             cnt_ff;
   logic signed [PRW-1:0]  prod_ff;
   logic signed [ACW-1:0]  acc_ff;
   logic                   done_ff;
   logic                   neg_ff;

   logic signed [NB-1:0]     n_sel;
   logic signed [WORD_W-1:0] p_sel;
   logic signed [WORD_W-1:0] p_axial;
   logic signed [PRW-1:0]    prod_in;
   logic signed [AXW-1:0]    d_axial;
   logic signed [DW-1:0]     d_general;

   // pick the component for this multiply cycle
   always_comb begin
      unique case (cnt_ff)
         2'd0: begin
            n_sel = norm_x;
            p_sel = pt_x;
         end
         2'd1: begin
            n_sel = norm_y;
            p_sel = pt_y;
         end
         2'd2: begin
            n_sel = norm_z;
            p_sel = pt_z;
         end
         default: begin
            n_sel = '0;
            p_sel = '0;
         end
      endcase
   end

   // pick the coordinate of an axial plane
   always_comb begin
      unique case (kind)
         KIND_X:  p_axial = pt_x;
         KIND_Y:  p_axial = pt_y;
         KIND_Z:  p_axial = pt_z;
         default: p_axial = pt_x;
      endcase
   end

   assign prod_in   = PRW'(n_sel) * PRW'(p_sel);
   assign d_axial   = AXW'(p_axial) - AXW'(plane_offset);
   assign d_general = DW'(acc_ff >>> FRAC_BITS) - DW'(plane_offset);

   // sequence the multiply-accumulate and flag the sign
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         neg_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  if (kind < AXIAL_KINDS) begin
                     done_ff <= 1'b1;
                     neg_ff  <= d_axial[AXW-1];
                  end else begin
                     cnt_ff   <= '0;
                     acc_ff   <= '0;
                     state_ff <= D_MUL;
                  end
               end
            end
            D_MUL: begin
               prod_ff <= prod_in;
               if (cnt_ff != 2'd0) begin
                  acc_ff <= acc_ff + ACW'(prod_ff);
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= D_FINAL;
               end
            end
            D_FINAL: begin
               done_ff  <= 1'b1;
               neg_ff   <= d_general[DW-1];
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign status.done = done_ff;
   assign status.neg  = neg_ff;

endmodule

FILE: rtl/bsp_hull_point_classify_top.sv
// Top level of the hull point classifier: node and plane memories, walk
// sequencer, configuration registers.
// Depends on bhpc_pkg, bhpc_rem_const and bhpc_dist_unit.
`timescale 1ns / 1ps
//
// Usage:
//   An item is taken when start is high and busy is low. op selects a node
//   write, a plane write or a point classify; op 3 is dropped.
//   Writes pass through take, slot reduction and memory write and give no
//   result. A classify walks the node memory one node per step and gives
//   one result on rsp_data with rsp_valid high for exactly one cycle.
//   Each step reads the node memory, then the plane memory (registered
//   synchronous reads), then runs the distance unit; the three products
//   of a general plane go through one shared multiplier.
//   The result cannot be held off; busy drops in the cycle it shows, so the
//   next item may be taken while the result is on the ports.
//   csr_we writes first_node (index 0) or last_node (index 1) at once.
//   Reset is synchronous: the sequencer returns to idle and the CSRs take
//   their reset values; memory contents are undefined until written.

module bsp_hull_point_classify_top
   import bhpc_pkg::*;
#(
   parameter int NODE_COUNT  = 4096,
   parameter int PLANE_COUNT = 4096,
   parameter int MAX_WALK    = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int NAW    = $clog2(NODE_COUNT);
   localparam int PAW    = $clog2(PLANE_COUNT);
   localparam int NB     = FRAC_BITS + 2;
   localparam int STEP_W = $clog2(MAX_WALK + 1);
   localparam int CW     = CHILD_W + 1;

   typedef struct packed {
      logic [PAW-1:0]            plane_ref;
      logic signed [CHILD_W-1:0] front;
      logic signed [CHILD_W-1:0] back;
   } node_entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [NB-1:0]     nx;
      logic signed [NB-1:0]     ny;
      logic signed [NB-1:0]     nz;
      logic signed [WORD_W-1:0] plane_offset;
   } plane_entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_CALC,
      S_WR_COMMIT,
      S_WALK,
      S_NODE_RD,
      S_PLANE_RD,
      S_DIST_WAIT
   } state_type;

   node_entry_type  node_mem [NODE_COUNT];
   plane_entry_type plane_mem [PLANE_COUNT];

   state_type                 state_ff;
   req_type                   item_ff;
   logic signed [CHILD_W-1:0] num_ff;
   logic [STEP_W-1:0]         steps_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;
   logic [CSR_W-1:0]          first_node_ff;
   logic [CSR_W-1:0]          last_node_ff;
   node_entry_type            node_q_ff;
   plane_entry_type           plane_q_ff;

   logic [NAW-1:0]  node_slot;
   logic [PAW-1:0]  plane_slot;
   logic [PAW-1:0]  ref_slot;
   logic            node_we;
   logic            plane_we;
   node_entry_type  node_wr;
   plane_entry_type plane_wr;
   logic [CW-1:0]   num_ext;
   logic            walk_bad;
   logic            accept;
   dist_rsp_type    dist_status;

   // reduce write slots and plane references into range
   bhpc_rem_const #(.DIV(NODE_COUNT)) u_node_slot (
      .clock (clock),
      .value (item_ff.index),
      .rem   (node_slot)
   );

   bhpc_rem_const #(.DIV(PLANE_COUNT)) u_plane_slot (
      .clock (clock),
      .value (item_ff.index),
      .rem   (plane_slot)
   );

   bhpc_rem_const #(.DIV(PLANE_COUNT)) u_ref_slot (
      .clock (clock),
      .value (item_ff.plane_ref),
      .rem   (ref_slot)
   );

   bhpc_dist_unit #(.FRAC_BITS(FRAC_BITS)) u_dist (
      .clock        (clock),
      .reset        (reset),
      .start        (state_ff == S_PLANE_RD),
      .kind         (plane_q_ff.kind),
      .norm_x       (plane_q_ff.nx),
      .norm_y       (plane_q_ff.ny),
      .norm_z       (plane_q_ff.nz),
      .plane_offset (plane_q_ff.plane_offset),
      .pt_x         (item_ff.vec_x),
      .pt_y         (item_ff.vec_y),
      .pt_z         (item_ff.vec_z),
      .status       (dist_status)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // build memory write entries
   assign node_we  = (state_ff == S_WR_COMMIT) && (item_ff.op == OP_WRITE_NODE);
   assign plane_we = (state_ff == S_WR_COMMIT) && (item_ff.op == OP_WRITE_PLANE);

   assign node_wr.plane_ref = ref_slot;
   assign node_wr.front     = item_ff.child_front;
   assign node_wr.back      = item_ff.child_back;

   assign plane_wr.kind         = item_ff.plane_kind;
   assign plane_wr.nx           = item_ff.vec_x[NB-1:0];
   assign plane_wr.ny           = item_ff.vec_y[NB-1:0];
   assign plane_wr.nz           = item_ff.vec_z[NB-1:0];
   assign plane_wr.plane_offset = item_ff.plane_dist;

   // node and plane memories, registered read
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_slot] <= node_wr;
      end
      node_q_ff <= node_mem[num_ff[NAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (plane_we) begin
         plane_mem[plane_slot] <= plane_wr;
      end
      plane_q_ff <= plane_mem[node_q_ff.plane_ref];
   end

   // node range and walk length check
   assign num_ext  = {1'b0, num_ff};
   assign walk_bad = (steps_ff >= STEP_W'(MAX_WALK))
                  || (num_ext < CW'(first_node_ff))
                  || (num_ext > CW'(last_node_ff))
                  || (num_ext >= CW'(NODE_COUNT));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_node_ff <= FIRST_NODE_RESET;
         last_node_ff  <= LAST_NODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_NODE: first_node_ff <= csr_wdata;
            CSR_LAST_NODE:  last_node_ff  <= csr_wdata;
            default:        first_node_ff <= first_node_ff;
         endcase
      end
   end

   // walk sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  item_ff  <= req_data;
                  num_ff   <= CHILD_W'(req_data.index);
                  steps_ff <= '0;
                  priority if (req_data.op == OP_WRITE_NODE ||
                               req_data.op == OP_WRITE_PLANE) begin
                     state_ff <= S_WR_CALC;
                  end else if (req_data.op == OP_CLASSIFY) begin
                     state_ff <= S_WALK;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_WR_CALC: state_ff <= S_WR_COMMIT;
            S_WR_COMMIT: state_ff <= S_IDLE;
            S_WALK: begin
               priority if (num_ff[CHILD_W-1]) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.contents <= num_ff;
                  rsp_data_ff.bad_node <= 1'b0;
                  state_ff             <= S_IDLE;
               end else if (walk_bad) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.contents <= '0;
                  rsp_data_ff.bad_node <= 1'b1;
                  state_ff             <= S_IDLE;
               end else begin
                  steps_ff <= steps_ff + STEP_W'(1);
                  state_ff <= S_NODE_RD;
               end
            end
            S_NODE_RD: state_ff <= S_PLANE_RD;
            S_PLANE_RD: state_ff <= S_DIST_WAIT;
            S_DIST_WAIT: begin
               if (dist_status.done) begin
                  num_ff   <= dist_status.neg ? node_q_ff.back : node_q_ff.front;
                  state_ff <= S_WALK;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
